// ===== rtl/core/hrp_pkg.sv =====
package hrp_pkg;

    // Default sizing handed to the top level.
    localparam int BUFFER_BYTES_DEF = 8192;
    localparam int HEADER_LIMIT_DEF = 64;

    // Register reset values, before clamping.
    localparam int MAX_REQUEST_LEN_RST = 8192;
    localparam int MAX_HEADERS_RST     = 32;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_REQUEST_LEN = 2'd0;
    localparam logic [1:0] CFG_MAX_HEADERS     = 2'd1;

    // Entries of the queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_START,
        PH_METHOD,
        PH_PATH,
        PH_PROTOCOL,
        PH_KEY,
        PH_VALUE,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        EV_METHOD,
        EV_PATH,
        EV_PROTOCOL,
        EV_KEY,
        EV_VALUE,
        EV_DONE,
        EV_OVERFLOW,
        EV_INCOMPLETE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  header_index;
        logic [12:0] span_start;
        logic [12:0] span_length;
        logic [6:0]  header_total;
        logic        last_event;
    } t_event;

    // All events caused by one byte; the second one is used only when two is set.
    typedef struct packed {
        logic   two;
        t_event ev0;
        t_event ev1;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/core/hrp_front.sv =====
module hrp_front #(
    parameter int BUFFER_BYTES = hrp_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_LIMIT = hrp_pkg::HEADER_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_stream,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [13:0]         i_cfg_data,
    input  hrp_pkg::t_qstat     i_qstat,
    output logic                o_push,
    output hrp_pkg::t_pair      o_pair
);
    import hrp_pkg::*;

    localparam int OFF_W = $clog2(BUFFER_BYTES);
    localparam int HW    = $clog2(HEADER_LIMIT + 1);
    localparam int CW    = (OFF_W + 1 > 14) ? OFF_W + 1 : 14;
    localparam int HCW   = (HW > 7) ? HW : 7;
    localparam int SW    = (OFF_W > 13) ? OFF_W : 13;
    localparam int LIM_RST = (MAX_REQUEST_LEN_RST < BUFFER_BYTES) ?
                             MAX_REQUEST_LEN_RST : BUFFER_BYTES;
    localparam int HMAX_RST = (MAX_HEADERS_RST < HEADER_LIMIT) ?
                              MAX_HEADERS_RST : HEADER_LIMIT;

    function automatic logic [12:0] pos13(input logic [OFF_W-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return w[12:0];
    endfunction

    function automatic logic [HCW-1:0] hwide(input logic [HW-1:0] v);
        return HCW'(v);
    endfunction

    function automatic t_event mk(input t_kind k, input logic [5:0] idx,
                                  input logic [12:0] st, input logic [12:0] len,
                                  input logic [6:0] tot);
        t_event e;
        e.kind         = k;
        e.header_index = idx;
        e.span_start   = st;
        e.span_length  = len;
        e.header_total = tot;
        e.last_event   = 1'b0;
        return e;
    endfunction

    // Limits are clamped when written, so the byte path sees ready values.
    logic [OFF_W-1:0] r_lim_m1;
    logic [HW-1:0]    r_hmax;
    logic [CW-1:0]    cfg_len;
    logic [HCW-1:0]   cfg_hdr;
    logic [CW-1:0]    lim_c;
    logic [HCW-1:0]   hmax_c;

    always_comb begin
        cfg_len = CW'(i_cfg_data);
        cfg_hdr = HCW'(i_cfg_data[6:0]);
        if (cfg_len < CW'(2)) begin
            lim_c = CW'(2);
        end else if (cfg_len > CW'(BUFFER_BYTES)) begin
            lim_c = CW'(BUFFER_BYTES);
        end else begin
            lim_c = cfg_len;
        end
        if (cfg_hdr < HCW'(1)) begin
            hmax_c = HCW'(1);
        end else if (cfg_hdr > HCW'(HEADER_LIMIT)) begin
            hmax_c = HCW'(HEADER_LIMIT);
        end else begin
            hmax_c = cfg_hdr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_m1 <= OFF_W'(LIM_RST - 1);
            r_hmax   <= HW'(HMAX_RST);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAX_REQUEST_LEN) begin
                r_lim_m1 <= OFF_W'(lim_c - CW'(1));
            end else if (i_cfg_index == CFG_MAX_HEADERS) begin
                r_hmax <= HW'(hmax_c);
            end
        end
    end

    t_phase           r_phase, n_phase;
    logic [OFF_W-1:0] r_off, n_off;
    logic [OFF_W-1:0] r_span, n_span;
    logic [HW-1:0]    r_hdr, n_hdr;
    logic             accept;
    logic [1:0]       cnt;
    t_event           ev0, ev1;
    logic [5:0]       idx6;
    logic [6:0]       tot_now, tot_next;
    logic [12:0]      len_now;

    assign o_in_stall = i_qstat.full;
    assign accept     = i_in_valid && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_off   <= '0;
            r_span  <= '0;
            r_hdr   <= '0;
        end else begin
            r_phase <= n_phase;
            r_off   <= n_off;
            r_span  <= n_span;
            r_hdr   <= n_hdr;
        end
    end

    always_comb begin
        t_event         e;
        logic [HCW-1:0] hdr_w;
        logic [HCW-1:0] hdr_w1;
        n_phase  = r_phase;
        n_off    = r_off;
        n_span   = r_span;
        n_hdr    = r_hdr;
        cnt      = 2'd0;
        ev0      = '0;
        ev1      = '0;
        e        = '0;
        hdr_w    = hwide(r_hdr);
        hdr_w1   = hwide(r_hdr + HW'(1));
        idx6     = hdr_w[5:0];
        tot_now  = hdr_w[6:0];
        tot_next = hdr_w1[6:0];
        len_now  = pos13(r_off - r_span);

        if (accept) begin
            if (r_phase != PH_DONE) begin
                if (r_off >= r_lim_m1) begin
                    ev0     = mk(EV_OVERFLOW, 6'd0, pos13(r_off), 13'd0, 7'd0);
                    cnt     = 2'd1;
                    n_phase = PH_DONE;
                end else begin
                    n_off = r_off + OFF_W'(1);
                    case (r_phase)
                        PH_START: begin
                            n_span  = r_off;
                            n_phase = PH_METHOD;
                        end
                        PH_METHOD, PH_PATH: begin
                            if (i_data_byte == CH_SP) begin
                                ev0 = mk((r_phase == PH_METHOD) ? EV_METHOD : EV_PATH,
                                         6'd0, pos13(r_span), len_now, 7'd0);
                                cnt     = 2'd1;
                                n_span  = r_off + OFF_W'(1);
                                n_phase = (r_phase == PH_METHOD) ? PH_PATH : PH_PROTOCOL;
                            end
                        end
                        PH_PROTOCOL: begin
                            if (i_data_byte == CH_CR) begin
                                ev0 = mk(EV_PROTOCOL, 6'd0, pos13(r_span), len_now, 7'd0);
                                cnt     = 2'd1;
                                n_span  = r_off + OFF_W'(1);
                                n_phase = PH_KEY;
                            end
                        end
                        PH_KEY: begin
                            if (i_data_byte inside {CH_SP, CH_LF}) begin
                                n_span = r_off + OFF_W'(1);
                            end else if (i_data_byte == CH_CR) begin
                                ev0 = mk(EV_DONE, 6'd0, pos13(r_off), 13'd0, tot_now);
                                cnt     = 2'd1;
                                n_phase = PH_DONE;
                            end else if (i_data_byte == CH_COLON) begin
                                ev0 = mk(EV_KEY, idx6, pos13(r_span), len_now, 7'd0);
                                cnt     = 2'd1;
                                n_span  = r_off + OFF_W'(1);
                                n_phase = PH_VALUE;
                            end
                        end
                        PH_VALUE: begin
                            if (i_data_byte inside {CH_SP, CH_LF}) begin
                                n_span = r_off + OFF_W'(1);
                            end else if (i_data_byte == CH_CR) begin
                                ev0 = mk(EV_VALUE, idx6, pos13(r_span), len_now, 7'd0);
                                cnt     = 2'd1;
                                n_span  = r_off + OFF_W'(1);
                                n_hdr   = r_hdr + HW'(1);
                                n_phase = PH_KEY;
                                // Header limit reached: the same byte also ends the head.
                                if (r_hdr + HW'(1) >= r_hmax) begin
                                    ev1 = mk(EV_DONE, 6'd0, pos13(r_off), 13'd0, tot_next);
                                    cnt     = 2'd2;
                                    n_phase = PH_DONE;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_DONE;
                        end
                    endcase
                end
            end

            if (i_end_of_stream) begin
                if (n_phase != PH_DONE) begin
                    e = mk(EV_INCOMPLETE, 6'd0, pos13(n_span), pos13(n_off), 7'd0);
                    if (cnt == 2'd0) begin
                        ev0 = e;
                        cnt = 2'd1;
                    end else begin
                        ev1 = e;
                        cnt = 2'd2;
                    end
                end
                n_phase = PH_START;
                n_off   = '0;
                n_span  = '0;
                n_hdr   = '0;
            end
        end

        if (cnt == 2'd1) begin
            ev0.last_event = 1'b1;
        end else if (cnt == 2'd2) begin
            ev1.last_event = 1'b1;
        end
    end

    assign o_push     = accept && (cnt != 2'd0);
    assign o_pair.two = (cnt == 2'd2);
    assign o_pair.ev0 = ev0;
    assign o_pair.ev1 = ev1;

endmodule

// ===== rtl/core/hrp_queue.sv =====
module hrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hrp_pkg::t_pair  i_pair,
    input  logic            i_pop,
    output hrp_pkg::t_pair  o_pair,
    output hrp_pkg::t_qstat o_qstat
);
    import hrp_pkg::*;

    localparam int QA = $clog2(QUEUE_DEPTH);

    t_pair         r_mem [QUEUE_DEPTH];
    logic [QA-1:0] r_wr, r_rd;
    logic [QA:0]   r_cnt;
    logic          do_push, do_pop;

    assign o_qstat.full  = (r_cnt == (QA+1)'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_pair        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QA'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QA'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QA+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QA+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/core/hrp_back.sv =====
module hrp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hrp_pkg::t_pair  i_pair,
    input  hrp_pkg::t_qstat i_qstat,
    output logic            o_pop,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output hrp_pkg::t_event o_event
);
    import hrp_pkg::*;

    logic   r_valid;
    logic   r_pend;
    t_event r_event;
    t_event r_second;
    logic   advance;

    // The output register moves whenever it is empty or its word is taken.
    assign advance     = !r_valid || !i_out_stall;
    assign o_pop       = advance && !r_pend && !i_qstat.empty;
    assign o_out_valid = r_valid;
    assign o_event     = r_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (advance) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_pend  <= i_pair.two;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (r_pend) begin
                r_event <= r_second;
            end else if (!i_qstat.empty) begin
                r_event  <= i_pair.ev0;
                r_second <= i_pair.ev1;
            end
        end
    end

endmodule

// ===== rtl/core/http_request_head_parser.sv =====
// HTTP request head parser.
// Input channel: one byte per word on i_data_byte, with i_end_of_stream set on
// the final byte of a stream. A word is taken when i_in_valid is high and
// o_in_stall is low. Output channel: one span event per word (kind, header
// index, span start and length, header total, last-event flag), taken when
// o_out_valid is high and i_out_stall is low.
// Configuration: i_cfg_index 0 writes max_request_len, 1 writes max_headers;
// o_cfg_ready is always high. Write only while the block is idle.
// Throughput is one byte per cycle while o_in_stall is low. A byte that causes
// two events (header limit reached, or an incomplete head on the last byte)
// takes two output words; the four-entry event queue absorbs such bursts. The
// first event of a byte is written into the queue when the byte is taken and
// moves on into the output register once that register is empty or its word
// is taken; the receiver takes it from there.
// Reset clears the parse state and the queue and restores the register reset
// values. A stalled receiver holds the output word; once the queue fills,
// o_in_stall rises and the parser stops taking bytes.
module http_request_head_parser #(
    parameter int BUFFER_BYTES = hrp_pkg::BUFFER_BYTES_DEF,
    parameter int HEADER_LIMIT = hrp_pkg::HEADER_LIMIT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [5:0]  o_header_index,
    output logic [12:0] o_span_start,
    output logic [12:0] o_span_length,
    output logic [6:0]  o_header_total,
    output logic        o_last_event,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);
    import hrp_pkg::*;

    t_pair  push_pair;
    t_pair  head_pair;
    t_qstat qstat;
    t_event out_event;
    logic   push;
    logic   pop;

    // Register writes are never held off, so the port is always ready.
    assign o_cfg_ready = 1'b1;

    // Front end: parse state and limits, classifies each byte into events.
    hrp_front #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .HEADER_LIMIT (HEADER_LIMIT)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_pair          (push_pair)
    );

    // Queue of per-byte event groups between parser and output stage.
    hrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .i_pop   (pop),
        .o_pair  (head_pair),
        .o_qstat (qstat)
    );

    // Back end: serializes each group into one event per output word.
    hrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pair      (head_pair),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_event     (out_event)
    );

    assign o_event_kind   = out_event.kind;
    assign o_header_index = out_event.header_index;
    assign o_span_start   = out_event.span_start;
    assign o_span_length  = out_event.span_length;
    assign o_header_total = out_event.header_total;
    assign o_last_event   = out_event.last_event;

endmodule

// ===== tb/http_head_event_checker.sv =====
module http_head_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_stream,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_event_kind,
    input  logic [5:0]  i_header_index,
    input  logic [12:0] i_span_start,
    input  logic [12:0] i_span_length,
    input  logic [6:0]  i_header_total,
    input  logic        i_last_event,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data,
    output int          o_pending,
    output int          o_errors
);
    import hrp_pkg::*;

    t_event      events_owed[$];
    t_phase      phase;
    int          offset;
    int          span_from;
    int          headers_seen;
    logic [13:0] len_reg;
    logic [6:0]  hdr_reg;
    int          err_count = 0;

    function automatic t_event span_event(input t_kind kind, input int index, input int start,
                                          input int length, input int total);
        t_event ev;
        ev.kind         = kind;
        ev.header_index = index[5:0];
        ev.span_start   = start[12:0];
        ev.span_length  = length[12:0];
        ev.header_total = total[6:0];
        ev.last_event   = 1'b0;
        return ev;
    endfunction

    task automatic clear_parse();
        phase        = PH_START;
        offset       = 0;
        span_from    = 0;
        headers_seen = 0;
    endtask

    // Works out the events one accepted byte causes and queues them in order.
    task automatic parse_byte(input logic [7:0] b, input logic eos);
        t_event evs[2];
        int     n;
        int     lim;
        int     hmax;
        int     off;
        n    = 0;
        lim  = len_reg;
        hmax = hdr_reg;
        if (lim < 2) lim = 2;
        if (lim > BUFFER_BYTES_DEF) lim = BUFFER_BYTES_DEF;
        if (hmax < 1) hmax = 1;
        if (hmax > HEADER_LIMIT_DEF) hmax = HEADER_LIMIT_DEF;

        if (phase != PH_DONE) begin
            off = offset;
            if (off >= lim - 1) begin
                evs[n] = span_event(EV_OVERFLOW, 0, off, 0, 0);
                n++;
                phase = PH_DONE;
            end else begin
                offset = off + 1;
                case (phase)
                    PH_START: begin
                        span_from = off;
                        phase     = PH_METHOD;
                    end
                    PH_METHOD: begin
                        if (b == CH_SP) begin
                            evs[n] = span_event(EV_METHOD, 0, span_from, off - span_from, 0);
                            n++;
                            span_from = off + 1;
                            phase     = PH_PATH;
                        end
                    end
                    PH_PATH: begin
                        if (b == CH_SP) begin
                            evs[n] = span_event(EV_PATH, 0, span_from, off - span_from, 0);
                            n++;
                            span_from = off + 1;
                            phase     = PH_PROTOCOL;
                        end
                    end
                    PH_PROTOCOL: begin
                        if (b == CH_CR) begin
                            evs[n] = span_event(EV_PROTOCOL, 0, span_from, off - span_from, 0);
                            n++;
                            span_from = off + 1;
                            phase     = PH_KEY;
                        end
                    end
                    PH_KEY: begin
                        if (b == CH_SP || b == CH_LF) begin
                            span_from = off + 1;
                        end else if (b == CH_CR) begin
                            evs[n] = span_event(EV_DONE, 0, off, 0, headers_seen);
                            n++;
                            phase = PH_DONE;
                        end else if (b == CH_COLON) begin
                            evs[n] = span_event(EV_KEY, headers_seen, span_from,
                                                off - span_from, 0);
                            n++;
                            span_from = off + 1;
                            phase     = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        if (b == CH_SP || b == CH_LF) begin
                            span_from = off + 1;
                        end else if (b == CH_CR) begin
                            evs[n] = span_event(EV_VALUE, headers_seen, span_from,
                                                off - span_from, 0);
                            n++;
                            span_from    = off + 1;
                            headers_seen = headers_seen + 1;
                            phase        = PH_KEY;
                            if (headers_seen >= hmax) begin
                                evs[n] = span_event(EV_DONE, 0, off, 0, headers_seen);
                                n++;
                                phase = PH_DONE;
                            end
                        end
                    end
                    default: phase = PH_DONE;
                endcase
            end
        end

        if (eos) begin
            if (phase != PH_DONE) begin
                evs[n] = span_event(EV_INCOMPLETE, 0, span_from, offset, 0);
                n++;
            end
            clear_parse();
        end

        if (n > 0) evs[n - 1].last_event = 1'b1;
        for (int i = 0; i < n; i++) events_owed.push_back(evs[i]);
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    task automatic take_event();
        t_event want;
        if (events_owed.size() == 0) begin
            $error("event of kind %0d arrived with none owed", i_event_kind);
            err_count++;
        end else begin
            want = events_owed.pop_front();
            check_field("event_kind", want.kind, i_event_kind);
            check_field("header_index", want.header_index, i_header_index);
            check_field("span_start", want.span_start, i_span_start);
            check_field("span_length", want.span_length, i_span_length);
            check_field("header_total", want.header_total, i_header_total);
            check_field("last_event", want.last_event, i_last_event);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            events_owed.delete();
            len_reg = 14'(MAX_REQUEST_LEN_RST);
            hdr_reg = 7'(MAX_HEADERS_RST);
            clear_parse();
        end else begin
            if (i_out_valid && !i_out_stall) take_event();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_REQUEST_LEN: len_reg = i_cfg_data;
                    CFG_MAX_HEADERS:     hdr_reg = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) parse_byte(i_data_byte, i_end_of_stream);
        end
        o_pending <= events_owed.size();
        o_errors  <= err_count;
    end

endmodule

// ===== tb/tb_http_request_head_parser.sv =====
module tb_http_request_head_parser;
    import hrp_pkg::*;

    // Chance in a hundred that a side idles in a given cycle.
    localparam int IDLE_PCT       = 7;
    // Cycles allowed after the last owed event before a register write. A byte
    // that causes no event only changes the parse state and is never queued.
    localparam int HOLD_CYCLES    = 8;
    // Cycles in a row with no word moving on any channel before giving up.
    localparam int WATCHDOG_LIMIT = 2000;

    // Every input of the block starts at a known value.
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_data_byte     = '0;
    logic        i_end_of_stream = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = CFG_MAX_REQUEST_LEN;
    logic [13:0] i_cfg_data      = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_event_kind;
    logic [5:0]  o_header_index;
    logic [12:0] o_span_start;
    logic [12:0] o_span_length;
    logic [6:0]  o_header_total;
    logic        o_last_event;
    logic        o_cfg_ready;

    // When steady is set, neither side idles; this gives a long back-to-back run.
    logic        steady = 1'b0;
    logic [7:0]  head_bytes[$];
    int          owed;
    int          faults;
    int          stuck_cycles = 0;

    wire progress = (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                    (i_cfg_valid && o_cfg_ready);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    http_request_head_parser u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_header_index  (o_header_index),
        .o_span_start    (o_span_start),
        .o_span_length   (o_span_length),
        .o_header_total  (o_header_total),
        .o_last_event    (o_last_event),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // The checker follows every channel, predicts the events and compares them.
    // It reports how many events are still owed and how many mismatches it saw.
    http_head_event_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_event_kind    (o_event_kind),
        .i_header_index  (o_header_index),
        .i_span_start    (o_span_start),
        .i_span_length   (o_span_length),
        .i_header_total  (o_header_total),
        .i_last_event    (o_last_event),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (owed),
        .o_errors        (faults)
    );

    // The receiver stalls at random, independently of what the block offers.
    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // A hang anywhere, including events that never come, ends the run here.
    always @(posedge i_clk) begin
        if (progress) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("tb_http_request_head_parser: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offers one byte and returns at the edge where it is taken. Valid stays high
    // on return so that the next byte can follow without a gap; the caller lowers
    // it when the sender goes quiet.
    task automatic send_word(input logic [7:0] b, input logic eos);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Sends the bytes collected in head_bytes, marking the last one as the end of
    // the stream so the parser starts over afterwards.
    task automatic send_stream();
        foreach (head_bytes[i]) send_word(head_bytes[i], i == head_bytes.size() - 1);
    endtask

    // The sender stops and waits until every owed event has come out, then lets
    // the output path run dry.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the write valid high; set_limits lowers it after the second word.
    task automatic write_reg(input logic [1:0] index, input logic [13:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_limits(input int len, input int hdr);
        settle();
        write_reg(CFG_MAX_REQUEST_LEN, len[13:0]);
        write_reg(CFG_MAX_HEADERS, hdr[13:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // A byte with no meaning to the parser in any phase.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c == CH_SP || c == CH_CR || c == CH_LF || c == CH_COLON) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // Key and value text now and then holds a space or a line feed, which moves
    // the span start. Values may also hold a colon, which is plain text there.
    function automatic logic [7:0] span_char(input logic in_value);
        case ($urandom_range(15))
            0:       return CH_SP;
            1:       return CH_LF;
            2:       return in_value ? CH_COLON : plain_char();
            default: return plain_char();
        endcase
    endfunction

    // A well-formed head with random content: request line, up to four header
    // lines, the blank line, and sometimes a little trailing body.
    task automatic build_head();
        head_bytes.delete();
        repeat ($urandom_range(1, 4)) head_bytes.push_back(plain_char());
        head_bytes.push_back(CH_SP);
        repeat ($urandom_range(1, 6)) head_bytes.push_back(plain_char());
        head_bytes.push_back(CH_SP);
        repeat ($urandom_range(1, 4)) head_bytes.push_back(plain_char());
        head_bytes.push_back(CH_CR);
        head_bytes.push_back(CH_LF);
        repeat ($urandom_range(0, 4)) begin
            repeat ($urandom_range(1, 4)) head_bytes.push_back(span_char(1'b0));
            head_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 5)) head_bytes.push_back(span_char(1'b1));
            head_bytes.push_back(CH_CR);
            head_bytes.push_back(CH_LF);
        end
        head_bytes.push_back(CH_CR);
        head_bytes.push_back(CH_LF);
        repeat ($urandom_range(0, 2)) head_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic build_noise();
        head_bytes.delete();
        repeat ($urandom_range(2, 16)) head_bytes.push_back(8'($urandom_range(255)));
    endtask

    // One setting of the registers and a budget of bytes under it. Most streams
    // are complete heads; some are cut short, which ends them on an incomplete
    // event unless the head already ended or overflowed, and the rest are raw noise.
    task automatic run_phase(input int len, input int hdr, input int budget, input logic calm);
        int sent;
        int pick;
        int cut;
        set_limits(len, hdr);
        steady <= calm;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                build_head();
                if (pick >= 62) begin
                    cut = $urandom_range(1, head_bytes.size() - 1);
                    repeat (cut) void'(head_bytes.pop_back());
                end
            end else begin
                build_noise();
            end
            send_stream();
            sent += head_bytes.size();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Header limit of one, with both registers written above their range and
        // below it so they clamp. The stream hits the byte extremes, an empty
        // protocol and key, a line feed and a space that move the span start, and
        // a value whose closing CR also ends the head. The final byte, marked as
        // the end of the stream, comes after the head is done and is ignored.
        set_limits(16383, 0);
        head_bytes = '{8'hFF, CH_SP, 8'h00, CH_SP, CH_CR, CH_LF, CH_COLON, CH_SP,
                       8'h78, CH_CR, 8'h41};
        send_stream();

        // Smallest buffer: the second byte already overflows, and the rest of the
        // stream is dropped until its last byte resets the parser.
        set_limits(1, 127);
        head_bytes = '{8'h41, 8'h42, 8'h43};
        send_stream();

        // A short buffer. The first stream ends on the space that closes the path,
        // so that byte yields the path event and the incomplete event. The head of the
        // second stream ends on a bare CR where a key is expected, one byte before the
        // buffer would overflow, and the byte after it is ignored.
        set_limits(8, 65);
        head_bytes = '{8'h47, CH_SP, 8'h2F, CH_SP};
        send_stream();
        head_bytes = '{8'h61, CH_SP, 8'h62, CH_SP, 8'h63, CH_CR, CH_CR, 8'h7A};
        send_stream();

        // Random heads under a range of settings, the reset values and the limits
        // among them. The third phase runs with no idling on either side.
        run_phase(8192, 32, 60, 1'b0);
        run_phase(100, 3, 55, 1'b0);
        run_phase(8191, 64, 70, 1'b1);
        run_phase(24, 1, 50, 1'b0);
        run_phase(2, 2, 25, 1'b0);
        run_phase(16000, 100, 55, 1'b0);
        run_phase(60, 5, 65, 1'b0);

        settle();
        if (faults == 0) begin
            $display("tb_http_request_head_parser: done, clean");
        end else begin
            $display("tb_http_request_head_parser: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hrp_pkg.sv
rtl/core/hrp_front.sv
rtl/core/hrp_queue.sv
rtl/core/hrp_back.sv
rtl/core/http_request_head_parser.sv
tb/http_head_event_checker.sv
tb/tb_http_request_head_parser.sv
